[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/mpbc_pkg.sv]
// ---------------------------------------------------------------------------
// mpbc_pkg
// Types, constants and bit-packing helpers of the packet block cipher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mpbc_pkg;

  localparam int WORDS           = 4;
  localparam int WORD_W          = 18;
  localparam int PROD_W          = 32;
  localparam int BITS_PER_STAGE  = 4;
  localparam int MOD_STAGES      = PROD_W / BITS_PER_STAGE;

  localparam logic [7:0] CHK_SEED = 8'hF8;
  localparam logic [7:0] LEN_SALT = 8'h3D;

  // Register indexes
  localparam logic [2:0] REG_MOD_LO = 3'd0;
  localparam logic [2:0] REG_MOD_HI = 3'd1;
  localparam logic [2:0] REG_ENC_LO = 3'd2;
  localparam logic [2:0] REG_ENC_HI = 3'd3;
  localparam logic [2:0] REG_DEC_LO = 3'd4;
  localparam logic [2:0] REG_DEC_HI = 3'd5;
  localparam logic [2:0] REG_XOR_LO = 3'd6;
  localparam logic [2:0] REG_XOR_HI = 3'd7;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [WORDS-1:0][WORD_W-1:0] words_t;

  // Per-item context that rides along the pipeline
  typedef struct packed {
    logic        op;
    words_t      src;   // plaintext words (encrypt) or unchained words (decrypt)
    logic [3:0]  len;
    logic [7:0]  c0;
    logic [7:0]  c1;
    words_t      res;   // per-word results filled in by the word units
  } ctx_t;

  // One restoring step of the remainder: shift in a bit, subtract if it fits
  function automatic logic [WORD_W-1:0] rem_step(input logic [WORD_W-1:0] r,
                                                 input logic bit_in,
                                                 input logic [WORD_W-1:0] m);
    logic [WORD_W:0] t;
    t = {r, bit_in};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[WORD_W-1:0];
  endfunction

  // Pack four words and two check bytes MSB-first; byte k lands in [8k+7:8k]
  function automatic logic [87:0] pack_stream(input words_t e, input logic [7:0] b9,
                                              input logic [7:0] b10);
    logic [87:0] seq;
    logic [87:0] bytes;
    seq = {e[0][7:0], e[0][15:8], e[0][17], e[0][16],
           e[1][7:0], e[1][15:8], e[1][17], e[1][16],
           e[2][7:0], e[2][15:8], e[2][17], e[2][16],
           e[3][7:0], e[3][15:8], e[3][17], e[3][16], b9, b10};
    for (int k = 0; k < 11; k++) begin
      bytes[8*k +: 8] = seq[87-8*k -: 8];
    end
    return bytes;
  endfunction

  // Undo the packing of the four words
  function automatic words_t unpack_words(input logic [87:0] bytes);
    logic [87:0] seq;
    logic [17:0] c;
    words_t      w;
    for (int k = 0; k < 11; k++) begin
      seq[87-8*k -: 8] = bytes[8*k +: 8];
    end
    for (int i = 0; i < WORDS; i++) begin
      c    = seq[87-18*i -: 18];
      w[i] = {c[1], c[0], c[9:2], c[17:10]};
    end
    return w;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mpbc_in_if.sv]
// ---------------------------------------------------------------------------
// mpbc_in_if
// Input word channel: operation and block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface mpbc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] block_low;
  logic [23:0] block_high;
  logic [3:0]  plain_length;
  modport source (output valid, op, block_low, block_high, plain_length, input ready);
  modport sink (input valid, op, block_low, block_high, plain_length, output ready);
endinterface
`default_nettype wire

[hw/rtl/mpbc_out_if.sv]
// ---------------------------------------------------------------------------
// mpbc_out_if
// Result word channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface mpbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_low;
  logic [23:0] out_high;
  logic [7:0]  recovered_length;
  logic        check_failed;
  modport source (output valid, out_low, out_high, recovered_length, check_failed,
                  input ready);
  modport sink (input valid, out_low, out_high, recovered_length, check_failed,
                output ready);
endinterface
`default_nettype wire

[hw/rtl/mpbc_cfg_if.sv]
// ---------------------------------------------------------------------------
// mpbc_cfg_if
// Configuration write channel: register index and data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface mpbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [35:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/mpbc_word_unit.sv]
// ---------------------------------------------------------------------------
// mpbc_word_unit
// Pipelined (a * b) mod 2^32 % m: one multiply stage, then a restoring
// remainder over the 32 product bits, a few bits per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpbc_word_unit import mpbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  ctx_t              in_ctx,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] m,
  output logic              out_valid,
  output ctx_t              out_ctx,
  output logic [WORD_W-1:0] rem
);

  logic              mul_valid;
  ctx_t              mul_ctx;
  logic [PROD_W-1:0] mul_prod;
  logic [WORD_W-1:0] mul_mod;

  logic              dv_valid [MOD_STAGES];
  ctx_t              dv_ctx   [MOD_STAGES];
  logic [WORD_W-1:0] dv_rem   [MOD_STAGES];
  logic [PROD_W-1:0] dv_num   [MOD_STAGES];
  logic [WORD_W-1:0] dv_mod   [MOD_STAGES];

  logic [2*WORD_W-1:0] prod_full;
  assign prod_full = a * b;

  // Multiply, keep the low 32 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
    end
    if (en) begin
      mul_ctx  <= in_ctx;
      mul_prod <= prod_full[PROD_W-1:0];
      mul_mod  <= m;
    end
  end

  // Remainder stages
  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_div
    logic              pv;
    ctx_t              pc;
    logic [WORD_W-1:0] pr;
    logic [PROD_W-1:0] pn;
    logic [WORD_W-1:0] pm;
    logic [WORD_W-1:0] r_next;

    if (s == 0) begin : g_first
      assign pv = mul_valid;
      assign pc = mul_ctx;
      assign pr = '0;
      assign pn = mul_prod;
      assign pm = mul_mod;
    end else begin : g_rest
      assign pv = dv_valid[s-1];
      assign pc = dv_ctx[s-1];
      assign pr = dv_rem[s-1];
      assign pn = dv_num[s-1];
      assign pm = dv_mod[s-1];
    end

    always_comb begin
      r_next = pr;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        r_next = rem_step(r_next, pn[PROD_W-1-j], pm);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s] <= 1'b0;
      end else if (en) begin
        dv_valid[s] <= pv;
      end
      if (en) begin
        dv_ctx[s] <= pc;
        dv_rem[s] <= r_next;
        dv_num[s] <= pn << BITS_PER_STAGE;
        dv_mod[s] <= pm;
      end
    end
  end

  // Zero modulus reduces to zero
  assign out_valid = dv_valid[MOD_STAGES-1];
  assign out_ctx   = dv_ctx[MOD_STAGES-1];
  assign rem       = (dv_mod[MOD_STAGES-1] == '0) ? '0 : dv_rem[MOD_STAGES-1];

endmodule
`default_nettype wire

[hw/rtl/modular_packet_block_cipher.sv]
// ---------------------------------------------------------------------------
// modular_packet_block_cipher
// Simple-modulus packet block cipher, 8-byte plain block to 11-byte cipher.
// ---------------------------------------------------------------------------
// The block takes one word per cycle and delivers one result per cycle while
// results are taken. Its pipeline is one unpack stage, four chained word
// units of 9 stages each (one multiply plus eight 4-bit remainder steps),
// and the output register. Each word unit needs the low half of the previous
// word's result, so the four units stand in series. When the result is not
// taken the whole pipeline holds. Configuration writes are always taken and
// must only be issued while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module modular_packet_block_cipher import mpbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mpbc_cfg_if.sink   cfg,
  mpbc_in_if.sink    din,
  mpbc_out_if.source dout
);

  logic [35:0] cfg_regs [8];
  logic        en;

  // Configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) begin
        cfg_regs[k] <= '0;
      end
    end else if (cfg.valid) begin
      cfg_regs[cfg.index] <= cfg.data;
    end
  end

  // Per-word keys, multipliers and moduli
  logic [WORD_W-1:0] key  [WORDS];
  logic [WORD_W-1:0] emul [WORDS];
  logic [WORD_W-1:0] dmul [WORDS];
  logic [WORD_W-1:0] modv [WORDS];
  for (genvar i = 0; i < WORDS; i++) begin : g_pick
    localparam int OFS = WORD_W * (i % 2);
    assign key[i]  = cfg_regs[REG_XOR_LO + 3'(i / 2)][OFS +: WORD_W];
    assign emul[i] = cfg_regs[REG_ENC_LO + 3'(i / 2)][OFS +: WORD_W];
    assign dmul[i] = cfg_regs[REG_DEC_LO + 3'(i / 2)][OFS +: WORD_W];
    assign modv[i] = cfg_regs[REG_MOD_LO + 3'(i / 2)][OFS +: WORD_W];
  end

  // Whole pipeline advances unless the output holds an untaken word
  assign en        = !dout.valid || dout.ready;
  assign din.ready = en;

  // Unpack stage
  ctx_t   u_ctx_next;
  words_t dw;
  always_comb begin
    dw = unpack_words({din.block_high, din.block_low});
    dw[2] = dw[2] ^ key[2] ^ {2'b0, dw[3][15:0]};
    dw[1] = dw[1] ^ key[1] ^ {2'b0, dw[2][15:0]};
    dw[0] = dw[0] ^ key[0] ^ {2'b0, dw[1][15:0]};
    u_ctx_next     = '0;
    u_ctx_next.op  = din.op;
    u_ctx_next.len = din.plain_length;
    u_ctx_next.c0  = din.block_high[15:8];
    u_ctx_next.c1  = din.block_high[23:16];
    if (din.op == OP_DECRYPT) begin
      u_ctx_next.src = dw;
    end else begin
      for (int i = 0; i < WORDS; i++) begin
        u_ctx_next.src[i] = {2'b0, din.block_low[16*i +: 16]};
      end
    end
  end

  logic wv [WORDS+1];
  ctx_t wc [WORDS+1];
  logic unp_valid;
  ctx_t unp_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      unp_valid <= 1'b0;
    end else if (en) begin
      unp_valid <= din.valid;
    end
    if (en) begin
      unp_ctx <= u_ctx_next;
    end
  end

  assign wv[0] = unp_valid;
  assign wc[0] = unp_ctx;

  // Chained word units
  for (genvar i = 0; i < WORDS; i++) begin : g_word
    localparam int P = (i == 0) ? 0 : i - 1;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [15:0]       t_enc;
    logic [15:0]       t_dec;
    logic              ov;
    ctx_t              oc;
    ctx_t              nc;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] p;

    assign t_enc = (i == 0) ? 16'h0 : wc[i].res[P][15:0];
    assign a = (wc[i].op == OP_DECRYPT) ? wc[i].src[i]
                                        : key[i] ^ wc[i].src[i] ^ {2'b0, t_enc};
    assign b = (wc[i].op == OP_DECRYPT) ? dmul[i] : emul[i];

    mpbc_word_unit u_unit (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (wv[i]),
      .in_ctx   (wc[i]),
      .a        (a),
      .b        (b),
      .m        (modv[i]),
      .out_valid(ov),
      .out_ctx  (oc),
      .rem      (r)
    );

    // Fold in the result of this word
    assign t_dec = (i == 0) ? 16'h0 : oc.src[P][15:0];
    assign p     = r ^ key[i] ^ {2'b0, t_dec};
    always_comb begin
      nc = oc;
      nc.res[i] = (oc.op == OP_DECRYPT) ? {2'b0, p[15:0]} : r;
    end
    assign wc[i+1] = nc;
    assign wv[i+1] = ov;
  end

  // Final chaining, packing and check
  ctx_t        fc;
  words_t      ech;
  logic [7:0]  chk;
  logic [7:0]  b9;
  logic [87:0] cipher;
  logic [63:0] plain;
  assign fc = wc[WORDS];
  always_comb begin
    chk = CHK_SEED;
    for (int i = 0; i < WORDS; i++) begin
      chk = chk ^ ((fc.op == OP_DECRYPT) ? fc.res[i][7:0] : fc.src[i][7:0])
                ^ ((fc.op == OP_DECRYPT) ? fc.res[i][15:8] : fc.src[i][15:8]);
      plain[16*i +: 16] = fc.res[i][15:0];
    end
    for (int i = 0; i < WORDS - 1; i++) begin
      ech[i] = fc.res[i] ^ key[i] ^ {2'b0, fc.res[i+1][15:0]};
    end
    ech[WORDS-1] = fc.res[WORDS-1];
    b9     = chk ^ {4'b0, fc.len} ^ LEN_SALT;
    cipher = pack_stream(ech, b9, chk);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= wv[WORDS];
    end
    if (en) begin
      if (fc.op == OP_DECRYPT) begin
        dout.out_low          <= plain;
        dout.out_high         <= '0;
        dout.check_failed     <= (chk != fc.c1);
        dout.recovered_length <= (chk != fc.c1) ? 8'h0 : (fc.c0 ^ fc.c1 ^ LEN_SALT);
      end else begin
        dout.out_low          <= cipher[63:0];
        dout.out_high         <= cipher[87:64];
        dout.check_failed     <= 1'b0;
        dout.recovered_length <= 8'h0;
      end
    end
  end

  // A failed check never reports a length
  `ASSERT_IMPLIES(a_fail_no_len, clk, rst, dout.valid && dout.check_failed,
                  dout.recovered_length == 8'h0, "length reported on failed check")
  // Cipher bytes 8 to 10 only appear on encrypt results
  `ASSERT_IMPLIES(a_high_enc, clk, rst, dout.valid && (dout.out_high != 24'h0),
                  !dout.check_failed && (dout.recovered_length == 8'h0),
                  "encrypt result carries decrypt status")
  // A held result keeps the pipeline frozen
  `ASSERT_NEXT(a_hold_stall, clk, rst, dout.valid && !dout.ready,
               dout.valid && $stable(wv[WORDS]), "pipeline moved during stall")

endmodule
`default_nettype wire
